[rtl/bhte_pkg.sv]
// bhte_pkg: shared types and constants for the bucketed hash table engine
// no dependencies; imported by bhte_hash and bucketed_hash_table_engine
package bhte_pkg;

  // default table geometry
  localparam int unsigned NumBucketsDef = 1024;
  localparam int unsigned SlotsDef      = 8;

  // field widths
  localparam int unsigned OpW    = 2;
  localparam int unsigned KeyW   = 32;
  localparam int unsigned SlotIW = 3;
  localparam int unsigned CountW = 14;

  // fmix32 multiplier constants
  localparam logic [31:0] MixC1 = 32'h85eb_ca6b;
  localparam logic [31:0] MixC2 = 32'hc2b2_ae35;

  // operation codes
  typedef enum logic [OpW-1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_DELETE = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // hash sequencer states
  typedef enum logic [2:0] {
    H_IDLE,
    H_MUL1,
    H_MUL2,
    H_RCP,
    H_QUO,
    H_MOD,
    H_DONE
  } hash_state_e;

  // table control states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_BUCKET,
    ST_READ,
    ST_CMP
  } tbl_state_e;

endpackage

[rtl/bhte_hash.sv]
// bhte_hash: fmix32 key hash on one shared 32x32 multiplier, then bucket select
// bucket select is a bit slice for power-of-two tables, else a reciprocal multiply
// depends on bhte_pkg
module bhte_hash #(
  parameter int unsigned NUM_BUCKETS = bhte_pkg::NumBucketsDef,
  parameter int unsigned BKT_W       = $clog2(NUM_BUCKETS)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [bhte_pkg::KeyW-1:0] key_i,
  output logic                     done_o,
  output logic [BKT_W-1:0]         bucket_o
);
  import bhte_pkg::*;

  localparam bit          IsPow2  = ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0);
  localparam logic [31:0] NumC    = 32'(NUM_BUCKETS);
  // round-up reciprocal: 2^(32+L)/N + 1 with the 2^32 bit dropped
  localparam logic [63:0] RcpFull = (64'd1 << (32 + BKT_W)) / 64'(NUM_BUCKETS);
  localparam logic [31:0] RcpM    = RcpFull[31:0] + 32'd1;
  localparam int unsigned QShift  = (BKT_W > 1) ? BKT_W - 1 : 0;

  hash_state_e state_q, state_d;
  logic [31:0]      x_q, x_d;
  logic [31:0]      t_q, t_d;
  logic [BKT_W-1:0] rem_q, rem_d;
  logic [31:0]      mul_a;
  logic [31:0]      mul_b;
  logic [63:0]      prod;
  logic [31:0]      prod_lo;

  // shared multiplier, operands picked by the sequencer
  assign mul_a = (state_q == H_MOD) ? t_q : x_q;

  always_comb begin
    case (state_q)
      H_MUL1:  mul_b = MixC1;
      H_MUL2:  mul_b = MixC2;
      H_RCP:   mul_b = RcpM;
      default: mul_b = NumC;
    endcase
  end

  assign prod    = {32'd0, mul_a} * {32'd0, mul_b};
  assign prod_lo = prod[31:0];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      H_IDLE:  if (start_i) state_d = H_MUL1;
      H_MUL1:  state_d = H_MUL2;
      H_MUL2:  state_d = IsPow2 ? H_DONE : H_RCP;
      H_RCP:   state_d = H_QUO;
      H_QUO:   state_d = H_MOD;
      H_MOD:   state_d = H_DONE;
      H_DONE:  state_d = H_IDLE;
      default: state_d = H_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    x_d   = x_q;
    t_d   = t_q;
    rem_d = rem_q;
    case (state_q)
      H_IDLE: begin
        if (start_i) x_d = key_i ^ (key_i >> 16);
      end
      H_MUL1: begin
        x_d = prod_lo ^ (prod_lo >> 13);
      end
      H_MUL2: begin
        x_d = prod_lo ^ (prod_lo >> 16);
      end
      // high half of hash times reciprocal
      H_RCP: begin
        t_d = prod[63:32];
      end
      // quotient fix-up for the 33-bit reciprocal
      H_QUO: begin
        t_d = (t_q + ((x_q - t_q) >> 1)) >> QShift;
      end
      // remainder fits the bucket width, so only low bits are subtracted
      H_MOD: begin
        rem_d = x_q[BKT_W-1:0] - prod[BKT_W-1:0];
      end
      default: begin
      end
    endcase
  end

  // outputs
  always_comb begin
    done_o   = (state_q == H_DONE);
    bucket_o = IsPow2 ? x_q[BKT_W-1:0] : rem_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    t_q   <= t_d;
    rem_q <= rem_d;
  end

endmodule

[rtl/bucketed_hash_table_engine.sv]
// bucketed_hash_table_engine: key-value hash table with fixed-size buckets
// depends on bhte_pkg and bhte_hash
//
// Command channel: present operation_i, key_i, value_i with start_i; the beat
// is taken at a rising edge where start_i is high and busy_o is low. Each
// command gives exactly one result beat: done_o is high for one cycle with
// ok_o, slot_index_o, found_value_o and item_count_o. The receiver cannot
// stall; results are never held back.
// After reset the occupancy memory is swept clear, one bucket per cycle, so
// busy_o stays high for the whole sweep, before the first command.
// Steps per command, from accept edge to result edge: fmix32 on the shared
// multiplier, then a reciprocal-multiply remainder when NUM_BUCKETS is not
// a power of two, then an occupancy read and a decide step. Insert and
// unused codes finish there. Lookup and delete then walk the bucket one slot
// at a time through the single key/value memory port: one check step per
// empty slot, a read and a compare step per occupied slot, and a final step
// when no slot matches. busy_o drops the cycle the result shows, and one
// command is in flight at a time.
module bucketed_hash_table_engine #(
  parameter int unsigned NUM_BUCKETS      = bhte_pkg::NumBucketsDef,
  parameter int unsigned SLOTS_PER_BUCKET = bhte_pkg::SlotsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [bhte_pkg::OpW-1:0]     operation_i,
  input  logic [bhte_pkg::KeyW-1:0]    key_i,
  input  logic [bhte_pkg::KeyW-1:0]    value_i,
  output logic                         done_o,
  output logic                         ok_o,
  output logic [bhte_pkg::SlotIW-1:0]  slot_index_o,
  output logic [bhte_pkg::KeyW-1:0]    found_value_o,
  output logic [bhte_pkg::CountW-1:0]  item_count_o
);
  import bhte_pkg::*;

  localparam int unsigned BktW   = $clog2(NUM_BUCKETS);
  localparam int unsigned SlotW  = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int unsigned SlotCW = $clog2(SLOTS_PER_BUCKET + 1);
  localparam int unsigned AddrW  = $clog2(NUM_BUCKETS * SLOTS_PER_BUCKET);
  localparam int unsigned Depth  = NUM_BUCKETS * SLOTS_PER_BUCKET;
  localparam logic [BktW-1:0]   LastBkt  = BktW'(NUM_BUCKETS - 1);
  localparam logic [SlotCW-1:0] SlotEnd  = SlotCW'(SLOTS_PER_BUCKET);
  localparam logic [AddrW-1:0]  SlotMulC = AddrW'(SLOTS_PER_BUCKET);

  // memories
  logic [SLOTS_PER_BUCKET-1:0] occ_mem [NUM_BUCKETS];
  logic [KeyW-1:0]             key_mem [Depth];
  logic [KeyW-1:0]             val_mem [Depth];

  tbl_state_e state_q, state_d;

  logic [OpW-1:0]       op_q, op_d;
  logic [KeyW-1:0]      key_q, key_d;
  logic [KeyW-1:0]      val_q, val_d;
  logic [BktW-1:0]      bucket_q, bucket_d;
  logic [BktW-1:0]      clr_q, clr_d;
  logic [SlotCW-1:0]    slot_q, slot_d;
  logic [CountW-1:0]    count_q, count_d;
  logic                 done_q, done_d;
  logic                 ok_q, ok_d;
  logic [SlotIW-1:0]    sidx_q, sidx_d;
  logic [KeyW-1:0]      found_q, found_d;

  logic [SLOTS_PER_BUCKET-1:0] occ_rd_q;
  logic [KeyW-1:0]             key_rd_q;
  logic [KeyW-1:0]             val_rd_q;

  logic                  accept;
  logic                  hash_done;
  logic [BktW-1:0]       hash_bucket;
  logic                  has_free;
  logic [SlotW-1:0]      free_idx;
  logic [SlotW-1:0]      scan_idx;
  logic                  scan_occ;
  logic                  key_hit;
  logic [SlotW-1:0]      kv_slot;
  logic [AddrW-1:0]      kv_addr;

  logic                        occ_we;
  logic                        occ_re;
  logic [BktW-1:0]             occ_waddr;
  logic [SLOTS_PER_BUCKET-1:0] occ_wdata;
  logic                        kv_we;
  logic                        kv_re;

  assign accept = start_i && (state_q == ST_IDLE);

  // key hash and bucket select
  bhte_hash #(
    .NUM_BUCKETS(NUM_BUCKETS),
    .BKT_W      (BktW)
  ) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .key_i   (key_i),
    .done_o  (hash_done),
    .bucket_o(hash_bucket)
  );

  // lowest free slot of the bucket
  always_comb begin
    has_free = 1'b0;
    free_idx = '0;
    for (int i = SLOTS_PER_BUCKET - 1; i >= 0; i--) begin
      if (!occ_rd_q[i]) begin
        has_free = 1'b1;
        free_idx = SlotW'(i);
      end
    end
  end

  // slot walk for lookup and delete
  assign scan_idx = slot_q[SlotW-1:0];
  assign scan_occ = occ_rd_q[scan_idx];
  assign key_hit  = (key_rd_q == key_q);
  assign kv_slot  = (state_q == ST_BUCKET) ? free_idx : scan_idx;
  assign kv_addr  = AddrW'(bucket_q) * SlotMulC + AddrW'(kv_slot);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:  if (clr_q == LastBkt) state_d = ST_IDLE;
      ST_IDLE:   if (start_i) state_d = ST_HASH;
      ST_HASH:   if (hash_done) state_d = ST_BUCKET;
      ST_BUCKET: begin
        if (op_q == OP_LOOKUP || op_q == OP_DELETE) begin
          state_d = ST_READ;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        if (slot_q == SlotEnd) begin
          state_d = ST_IDLE;
        end else if (scan_occ) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP:    state_d = key_hit ? ST_IDLE : ST_READ;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath registers and result
  always_comb begin
    op_d     = op_q;
    key_d    = key_q;
    val_d    = val_q;
    bucket_d = bucket_q;
    clr_d    = clr_q;
    slot_d   = slot_q;
    count_d  = count_q;
    done_d   = 1'b0;
    ok_d     = ok_q;
    sidx_d   = sidx_q;
    found_d  = found_q;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + BktW'(1);
      end
      ST_IDLE: begin
        if (start_i) begin
          op_d  = operation_i;
          key_d = key_i;
          val_d = value_i;
        end
      end
      ST_HASH: begin
        bucket_d = hash_bucket;
        slot_d   = '0;
      end
      ST_BUCKET: begin
        if (op_q == OP_INSERT) begin
          done_d  = 1'b1;
          found_d = '0;
          if (has_free) begin
            ok_d    = 1'b1;
            sidx_d  = SlotIW'(free_idx);
            count_d = count_q + CountW'(1);
          end else begin
            ok_d   = 1'b0;
            sidx_d = '0;
          end
        end else if (op_q == OP_NONE) begin
          done_d  = 1'b1;
          ok_d    = 1'b0;
          sidx_d  = '0;
          found_d = '0;
        end
      end
      ST_READ: begin
        if (slot_q == SlotEnd) begin
          done_d  = 1'b1;
          ok_d    = 1'b0;
          sidx_d  = '0;
          found_d = '0;
        end else if (!scan_occ) begin
          slot_d = slot_q + SlotCW'(1);
        end
      end
      ST_CMP: begin
        if (key_hit) begin
          done_d = 1'b1;
          ok_d   = 1'b1;
          sidx_d = SlotIW'(scan_idx);
          if (op_q == OP_LOOKUP) begin
            found_d = val_rd_q;
          end else begin
            found_d = '0;
            count_d = count_q - CountW'(1);
          end
        end else begin
          slot_d = slot_q + SlotCW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // memory controls and handshake outputs
  always_comb begin
    busy_o    = (state_q != ST_IDLE);
    occ_we    = 1'b0;
    occ_re    = 1'b0;
    occ_waddr = bucket_q;
    occ_wdata = occ_rd_q;
    kv_we     = 1'b0;
    kv_re     = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        occ_we    = 1'b1;
        occ_waddr = clr_q;
        occ_wdata = '0;
      end
      ST_HASH: begin
        occ_re = hash_done;
      end
      ST_BUCKET: begin
        if (op_q == OP_INSERT && has_free) begin
          occ_we    = 1'b1;
          occ_wdata = occ_rd_q | (SLOTS_PER_BUCKET'(1) << free_idx);
          kv_we     = 1'b1;
        end
      end
      ST_READ: begin
        kv_re = (slot_q != SlotEnd) && scan_occ;
      end
      ST_CMP: begin
        if (key_hit && op_q == OP_DELETE) begin
          occ_we    = 1'b1;
          occ_wdata = occ_rd_q & ~(SLOTS_PER_BUCKET'(1) << scan_idx);
        end
      end
      default: begin
      end
    endcase
  end

  // occupancy memory, registered read
  always_ff @(posedge clk_i) begin
    if (occ_we) occ_mem[occ_waddr] <= occ_wdata;
    if (occ_re) occ_rd_q <= occ_mem[hash_bucket];
  end

  // key and value memories, one shared address, registered read
  always_ff @(posedge clk_i) begin
    if (kv_we) begin
      key_mem[kv_addr] <= key_q;
      val_mem[kv_addr] <= val_q;
    end
    if (kv_re) begin
      key_rd_q <= key_mem[kv_addr];
      val_rd_q <= val_mem[kv_addr];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    key_q    <= key_d;
    val_q    <= val_d;
    bucket_q <= bucket_d;
    slot_q   <= slot_d;
    ok_q     <= ok_d;
    sidx_q   <= sidx_d;
    found_q  <= found_d;
  end

  // result beat
  assign done_o        = done_q;
  assign ok_o          = ok_q;
  assign slot_index_o  = sidx_q;
  assign found_value_o = found_q;
  assign item_count_o  = count_q;

endmodule

[dv/tb_bucketed_hash_table_engine.sv]
// tb_bucketed_hash_table_engine: self-checking testbench for the bucketed hash table engine
// depends on bhte_pkg and bucketed_hash_table_engine; carries its own table model
`timescale 1ns / 100ps

module tb_bucketed_hash_table_engine;
  import bhte_pkg::*;

  localparam int unsigned NumBkt     = NumBucketsDef;
  localparam int unsigned NumSlot    = SlotsDef;
  localparam int unsigned StallLimit = 5000;

  // one result beat as the block reports it
  typedef struct packed {
    logic              ok;
    logic [SlotIW-1:0] slot;
    logic [KeyW-1:0]   value;
    logic [CountW-1:0] count;
  } table_resp_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic [OpW-1:0]    operation_i;
  logic [KeyW-1:0]   key_i;
  logic [KeyW-1:0]   value_i;
  logic              done_o;
  logic              ok_o;
  logic [SlotIW-1:0] slot_index_o;
  logic [KeyW-1:0]   found_value_o;
  logic [CountW-1:0] item_count_o;

  // shadow copy of the table
  logic [NumSlot-1:0] occ_shadow [NumBkt];
  logic [KeyW-1:0]    key_shadow [NumBkt*NumSlot];
  logic [KeyW-1:0]    val_shadow [NumBkt*NumSlot];
  logic [CountW-1:0]  count_shadow;

  table_resp_t pending_resp_q[$];
  logic [KeyW-1:0] hot_keys[$];

  int unsigned gap_pct;
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_hits;
  int unsigned n_errors;
  int unsigned stall_cycles;

  bucketed_hash_table_engine u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .operation_i  (operation_i),
    .key_i        (key_i),
    .value_i      (value_i),
    .done_o       (done_o),
    .ok_o         (ok_o),
    .slot_index_o (slot_index_o),
    .found_value_o(found_value_o),
    .item_count_o (item_count_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // murmur3 32-bit finalizer
  function automatic logic [KeyW-1:0] mix_key(input logic [KeyW-1:0] k);
    logic [KeyW-1:0] h;
    h = k ^ (k >> 16);
    h = h * MixC1;
    h = h ^ (h >> 13);
    h = h * MixC2;
    return h ^ (h >> 16);
  endfunction

  function automatic int unsigned bucket_of(input logic [KeyW-1:0] k);
    logic [KeyW-1:0] h;
    h = mix_key(k);
    return h % NumBkt;
  endfunction

  // apply one command to the shadow table and queue the result it should give
  task automatic predict_table_op(input op_e op, input logic [KeyW-1:0] k,
                                  input logic [KeyW-1:0] v);
    int unsigned bkt;
    int unsigned pos;
    table_resp_t r;
    bit hit;
    bkt = bucket_of(k);
    r   = '0;
    hit = 1'b0;
    case (op)
      OP_INSERT: begin
        for (int i = 0; i < NumSlot && !hit; i++) begin
          if (!occ_shadow[bkt][i]) begin
            pos = bkt * NumSlot + i;
            occ_shadow[bkt][i] = 1'b1;
            key_shadow[pos] = k;
            val_shadow[pos] = v;
            count_shadow = count_shadow + CountW'(1);
            r.ok   = 1'b1;
            r.slot = SlotIW'(i);
            hit    = 1'b1;
          end
        end
      end
      OP_LOOKUP, OP_DELETE: begin
        for (int i = 0; i < NumSlot && !hit; i++) begin
          pos = bkt * NumSlot + i;
          if (occ_shadow[bkt][i] && key_shadow[pos] == k) begin
            r.ok   = 1'b1;
            r.slot = SlotIW'(i);
            hit    = 1'b1;
            if (op == OP_LOOKUP) begin
              r.value = val_shadow[pos];
            end else begin
              occ_shadow[bkt][i] = 1'b0;
              key_shadow[pos] = '0;
              val_shadow[pos] = '0;
              count_shadow = count_shadow - CountW'(1);
            end
          end
        end
      end
      default: begin
        // unused code leaves the table alone
      end
    endcase
    r.count = count_shadow;
    pending_resp_q.push_back(r);
  endtask

  // drive one command beat; start stays high between back-to-back beats
  task automatic send_cmd(input op_e op, input logic [KeyW-1:0] k,
                          input logic [KeyW-1:0] v);
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i     <= 1'b1;
    operation_i <= op;
    key_i       <= k;
    value_i     <= v;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predict_table_op(op, k, v);
    n_sent++;
  endtask

  // collect n distinct keys that land in one bucket
  task automatic keys_for_bucket(input int unsigned bkt, input int unsigned n,
                                 ref logic [KeyW-1:0] q[$]);
    logic [KeyW-1:0] k;
    int unsigned got;
    k   = $urandom();
    got = 0;
    while (got < n) begin
      if (bucket_of(k) == bkt) begin
        q.push_back(k);
        got++;
      end
      k++;
    end
  endtask

  // key extremes, every operation, absent keys and the unused code
  task automatic test_basic_ops();
    send_cmd(OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    send_cmd(OP_DELETE, 32'hFFFF_FFFF, 32'h0000_0000);
    send_cmd(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
    send_cmd(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_cmd(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    send_cmd(OP_NONE,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(OP_DELETE, 32'h0000_0000, 32'h0000_0000);
    send_cmd(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_cmd(OP_DELETE, 32'hFFFF_FFFF, 32'h0000_0000);
  endtask

  // fill one bucket, overflow it, then reuse a freed middle slot
  task automatic test_bucket_full();
    logic [KeyW-1:0] fill_keys[$];
    keys_for_bucket($urandom_range(NumBkt - 1), NumSlot + 1, fill_keys);
    for (int i = 0; i <= NumSlot; i++) send_cmd(OP_INSERT, fill_keys[i], $urandom());
    send_cmd(OP_DELETE, fill_keys[3], $urandom());
    send_cmd(OP_INSERT, fill_keys[NumSlot], $urandom());
  endtask

  // duplicate keys: lowest matching slot wins, the copy shows after delete
  task automatic test_duplicate_keys();
    logic [KeyW-1:0] k;
    k = $urandom();
    send_cmd(OP_INSERT, k, $urandom());
    send_cmd(OP_INSERT, k, $urandom());
    send_cmd(OP_LOOKUP, k, $urandom());
    send_cmd(OP_DELETE, k, $urandom());
    send_cmd(OP_LOOKUP, k, $urandom());
  endtask

  // random traffic, mostly on a few crowded buckets so they fill and drain
  task automatic test_random(input int unsigned n_cmds, input int unsigned idle_pct);
    int unsigned pick;
    op_e op;
    logic [KeyW-1:0] k;
    gap_pct = idle_pct;
    for (int n = 0; n < n_cmds; n++) begin
      pick = $urandom_range(99);
      if (pick < 40)      op = OP_INSERT;
      else if (pick < 70) op = OP_LOOKUP;
      else if (pick < 95) op = OP_DELETE;
      else                op = OP_NONE;
      if ($urandom_range(99) < 75) k = hot_keys[$urandom_range(hot_keys.size() - 1)];
      else                         k = $urandom();
      send_cmd(op, k, $urandom());
    end
    gap_pct = 0;
  endtask

  // compare each result beat with the oldest prediction
  always @(posedge clk_i) begin : result_check
    table_resp_t want;
    if (rst_ni && done_o) begin
      if (pending_resp_q.size() == 0) begin
        $error("result beat with no command outstanding");
        n_errors++;
      end else begin
        want = pending_resp_q.pop_front();
        n_checked++;
        if (ok_o) n_hits++;
        if (ok_o !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, ok_o);
          n_errors++;
        end
        if (slot_index_o !== want.slot) begin
          $error("slot_index: expected %0d, got %0d", want.slot, slot_index_o);
          n_errors++;
        end
        if (found_value_o !== want.value) begin
          $error("found_value: expected %08h, got %08h", want.value, found_value_o);
          n_errors++;
        end
        if (item_count_o !== want.count) begin
          $error("item_count: expected %0d, got %0d", want.count, item_count_o);
          n_errors++;
        end
      end
    end
  end

  // watchdog on cycles with neither a command nor a result beat
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $error("no beat moved for %0d cycles", StallLimit);
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // test sequence
  initial begin
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    operation_i  = OP_INSERT;
    key_i        = '0;
    value_i      = '0;
    gap_pct      = 0;
    n_sent       = 0;
    n_checked    = 0;
    n_hits       = 0;
    n_errors     = 0;
    stall_cycles = 0;
    count_shadow = '0;
    for (int b = 0; b < NumBkt; b++) occ_shadow[b] = '0;
    for (int b = 0; b < 4; b++) keys_for_bucket($urandom_range(NumBkt - 1), 12, hot_keys);
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_basic_ops();
    test_bucket_full();
    test_duplicate_keys();
    test_random(383, 10);
    test_random(383, 85);
    test_random(384, 0);
    @(negedge clk_i);
    start_i <= 1'b0;

    // drain, then leave room for a stray late beat
    while (pending_resp_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("run covered %0d commands (insert, lookup, delete, unused code) on crowded buckets",
             n_sent);
    $display("%0d results checked, %0d succeeded, final entry count %0d",
             n_checked, n_hits, count_shadow);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/bhte_pkg.sv
rtl/bhte_hash.sv
rtl/bucketed_hash_table_engine.sv
dv/tb_bucketed_hash_table_engine.sv
